// ===== rtl/core/life_generation_row_stencil_macros.svh =====
// assertion macros shared by the life row stencil modules
`ifndef LIFE_GENERATION_ROW_STENCIL_MACROS_SVH
`define LIFE_GENERATION_ROW_STENCIL_MACROS_SVH

// condition holds whenever reset is released
`define LGRS_ASSERT_NOW(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LGRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LGRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lgrs_pkg.sv =====
// shared constants and the cell rule of the life row stencil
package lgrs_pkg;

    localparam int ROW_WIDTH_DEF = 64;
    localparam int GRID_WIDTH_W  = 7;
    localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST = 7'd64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NBR_CNT_W     = 4;

    // birth on three neighbors, survival on two or three
    function automatic logic life_next(input logic alive, input logic [NBR_CNT_W-1:0] cnt);
        return (cnt == 4'd3) || ((cnt == 4'd2) && alive);
    endfunction

endpackage

// ===== rtl/core/lgrs_front.sv =====
// front end: width register, row history and classification into queue words
module lgrs_front #(
    parameter int ROW_WIDTH = lgrs_pkg::ROW_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lgrs_pkg::GRID_WIDTH_W-1:0]   i_cfg_wr_data,
    input  logic                                i_valid,
    input  logic [ROW_WIDTH-1:0]                i_row_cells,
    input  logic                                i_last_row,
    input  logic                                i_full,
    output logic                                o_push,
    output logic [4*ROW_WIDTH+1:0]              o_entry
);

    logic [lgrs_pkg::GRID_WIDTH_W-1:0] r_grid_width;
    logic [ROW_WIDTH-1:0]              r_upper;
    logic [ROW_WIDTH-1:0]              r_middle;
    logic                              r_held;
    logic [ROW_WIDTH-1:0]              col_mask;
    logic [ROW_WIDTH-1:0]              cur;
    logic                              accept;

    // column c in use when c is below the configured width
    always_comb begin
        for (int c = 0; c < ROW_WIDTH; c++) begin
            col_mask[c] = (lgrs_pkg::GRID_WIDTH_W'(c) < r_grid_width);
        end
    end

    assign cur     = i_row_cells & col_mask;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign o_entry = {r_upper, r_middle, cur, col_mask, r_held, i_last_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= lgrs_pkg::GRID_WIDTH_RST;
            r_upper      <= '0;
            r_middle     <= '0;
            r_held       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_grid_width <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_last_row) begin
                    r_upper  <= '0;
                    r_middle <= '0;
                    r_held   <= 1'b0;
                end else begin
                    r_upper  <= r_held ? r_middle : '0;
                    r_middle <= cur;
                    r_held   <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lgrs_fifo.sv =====
// small register queue between front and back
`include "life_generation_row_stencil_macros.svh"

module lgrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lgrs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `LGRS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count over depth")
    `LGRS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `LGRS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")

endmodule

// ===== rtl/core/lgrs_back.sv =====
// back end: neighbor counts, result sequencing and output register
`include "life_generation_row_stencil_macros.svh"

module lgrs_back #(
    parameter int ROW_WIDTH = lgrs_pkg::ROW_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_head_valid,
    input  logic [4*ROW_WIDTH+1:0]  i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ROW_WIDTH-1:0]    o_next_row_cells,
    output logic                    o_last_out
);

    logic [ROW_WIDTH-1:0] h_upper;
    logic [ROW_WIDTH-1:0] h_middle;
    logic [ROW_WIDTH-1:0] h_cur;
    logic [ROW_WIDTH-1:0] h_mask;
    logic                 h_held;
    logic                 h_last;

    logic                 r_phase;
    logic                 r_out_valid;
    logic [ROW_WIDTH-1:0] r_out_cells;
    logic                 r_out_last;

    logic                 out_free;
    logic                 a_pend;
    logic                 fire;
    logic                 emit;
    logic [ROW_WIDTH-1:0] sel_above;
    logic [ROW_WIDTH-1:0] sel_row;
    logic [ROW_WIDTH-1:0] sel_below;
    logic                 sel_last;
    logic [ROW_WIDTH+1:0] pad_above;
    logic [ROW_WIDTH+1:0] pad_row;
    logic [ROW_WIDTH+1:0] pad_below;
    logic [lgrs_pkg::NBR_CNT_W-1:0] nbr_cnt [ROW_WIDTH];
    logic [ROW_WIDTH-1:0] gen_row;

    assign {h_upper, h_middle, h_cur, h_mask, h_held, h_last} = i_head;

    // first result closes the held row, second one the bottom row
    assign out_free = !r_out_valid || !i_stall;
    assign a_pend   = h_held && !r_phase;
    assign fire     = i_head_valid && out_free;
    assign emit     = fire && (a_pend || h_last);
    assign o_pop    = fire && (!a_pend || !h_last);

    always_comb begin
        if (a_pend) begin
            sel_above = h_upper;
            sel_row   = h_middle;
            sel_below = h_cur;
            sel_last  = 1'b0;
        end else begin
            sel_above = h_held ? h_middle : '0;
            sel_row   = h_cur;
            sel_below = '0;
            sel_last  = 1'b1;
        end
    end

    // dead border column on each side
    assign pad_above = {1'b0, sel_above & h_mask, 1'b0};
    assign pad_row   = {1'b0, sel_row   & h_mask, 1'b0};
    assign pad_below = {1'b0, sel_below & h_mask, 1'b0};

    always_comb begin
        for (int c = 0; c < ROW_WIDTH; c++) begin
            nbr_cnt[c] = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
                       + 4'(pad_row[c]) + 4'(pad_row[c+2])
                       + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
            gen_row[c] = h_mask[c] && lgrs_pkg::life_next(pad_row[c+1], nbr_cnt[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_cells <= gen_row;
            r_out_last  <= sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase <= a_pend && h_last;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_next_row_cells = r_out_cells;
    assign o_last_out       = r_out_last;

    `LGRS_ASSERT_IMP(a_phase_ctx, i_clk, i_rst_n, r_phase, i_head_valid && h_held && h_last, "second result without a bottom row")
    `LGRS_ASSERT_NXT(a_phase_set, i_clk, i_rst_n, fire && a_pend && h_last, r_phase, "second result not scheduled")
    `LGRS_ASSERT_NXT(a_phase_clr, i_clk, i_rst_n, fire && !a_pend, !r_phase, "phase left set after bottom row")

endmodule

// ===== rtl/core/life_generation_row_stencil.sv =====
// top level of the life row stencil: front, queue and back
// path: an accepted row is written into the queue, then the back end registers its results in the output register
// throughput: one row per cycle while neither side stalls; a bottom row that also closes a held row
//   gives two results, produced one after the other by the single stencil unit in the back end
// reset (synchronous, active low): clears held rows, queue and output valid, width to 64
// a grid may start in any cycle after reset; no clearing pass is needed
module life_generation_row_stencil #(
    parameter int ROW_WIDTH   = lgrs_pkg::ROW_WIDTH_DEF,
    parameter int QUEUE_DEPTH = lgrs_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: grid width
    input  logic                              i_cfg_wr_en,
    input  logic [lgrs_pkg::GRID_WIDTH_W-1:0] i_cfg_wr_data,
    // input rows
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ROW_WIDTH-1:0]              i_row_cells,
    input  logic                              i_last_row,
    // output rows
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ROW_WIDTH-1:0]              o_next_row_cells,
    output logic                              o_last_out
);

    // queue word: upper, middle, current row, column mask, held flag, last flag
    localparam int ENTRY_W = 4 * ROW_WIDTH + 2;

    logic               q_push;
    logic [ENTRY_W-1:0] q_wr_data;
    logic               q_pop;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_rd_data;

    // input side stalls only on a full queue, so it waits on the output only once the queue has filled
    assign o_in_stall = q_full;

    // front: keeps the two previous rows and tags each word with the held and last flags
    lgrs_front #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_in_valid),
        .i_row_cells   (i_row_cells),
        .i_last_row    (i_last_row),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_entry       (q_wr_data)
    );

    // decoupling queue
    lgrs_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rd_data)
    );

    // back: zero, one or two generation rows per word
    lgrs_back #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (q_valid),
        .i_head           (q_rd_data),
        .o_pop            (q_pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_next_row_cells (o_next_row_cells),
        .o_last_out       (o_last_out)
    );

endmodule

// ===== verif/life_row_checker.sv =====
// checker for the life row stencil: predicts every output word and compares it
module life_row_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lgrs_pkg::GRID_WIDTH_W-1:0] i_cfg_wr_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [lgrs_pkg::ROW_WIDTH_DEF-1:0] i_row_cells,
    input  logic                              i_last_row,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [lgrs_pkg::ROW_WIDTH_DEF-1:0] i_next_row_cells,
    input  logic                              i_last_out,
    output int                                o_fail_count,
    output int                                o_pending
);
    localparam int RW = lgrs_pkg::ROW_WIDTH_DEF;

    typedef struct packed {
        logic [RW-1:0] cells;
        logic          last;
    } t_row_word;

    t_row_word                        expected_rows [$];
    logic [lgrs_pkg::GRID_WIDTH_W-1:0] grid_width;
    logic [RW-1:0]                    upper_row;
    logic [RW-1:0]                    middle_row;
    logic                             row_held;

    // columns in use; widths past the row are clamped to the row
    function automatic logic [RW-1:0] column_mask(input logic [lgrs_pkg::GRID_WIDTH_W-1:0] w);
        int n;
        n = (int'(w) > RW) ? RW : int'(w);
        if (n >= 64) begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    // one double-buffered generation of the middle row, dead cells beyond the edges
    function automatic logic [RW-1:0] next_generation(input logic [RW-1:0] above,
                                                      input logic [RW-1:0] row,
                                                      input logic [RW-1:0] below,
                                                      input logic [RW-1:0] mask);
        logic [RW+1:0] pa;
        logic [RW+1:0] pr;
        logic [RW+1:0] pb;
        logic [RW-1:0] res;
        int            n;
        pa  = {1'b0, above & mask, 1'b0};
        pr  = {1'b0, row & mask, 1'b0};
        pb  = {1'b0, below & mask, 1'b0};
        res = '0;
        for (int c = 0; c < RW; c++) begin
            n = int'(pa[c]) + int'(pa[c+1]) + int'(pa[c+2])
              + int'(pr[c]) + int'(pr[c+2])
              + int'(pb[c]) + int'(pb[c+1]) + int'(pb[c+2]);
            res[c] = (n == 3) || ((n == 2) && pr[c+1]);
        end
        return res & mask;
    endfunction

    always @(posedge i_clk) begin : track
        t_row_word     got;
        t_row_word     want;
        logic [RW-1:0] mask;
        logic [RW-1:0] cur;
        if (!i_rst_n) begin
            grid_width   = lgrs_pkg::GRID_WIDTH_RST;
            upper_row    = '0;
            middle_row   = '0;
            row_held     = 1'b0;
            o_fail_count = 0;
            expected_rows.delete();
        end else begin
            // outputs first: a word accepted now cannot belong to this edge's input
            if (i_out_valid && !i_out_stall) begin
                got.cells = i_next_row_cells;
                got.last  = i_last_out;
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual cells %h last %b",
                             $time, got.cells, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.cells !== want.cells) begin
                        $display("%0t: next_row_cells expected %h actual %h",
                                 $time, want.cells, got.cells);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                mask = column_mask(grid_width);
                cur  = i_row_cells & mask;
                if (row_held) begin
                    want.cells = next_generation(upper_row, middle_row, cur, mask);
                    want.last  = 1'b0;
                    expected_rows.push_back(want);
                end
                if (i_last_row) begin
                    want.cells = next_generation(row_held ? middle_row : '0, cur, '0, mask);
                    want.last  = 1'b1;
                    expected_rows.push_back(want);
                    upper_row  = '0;
                    middle_row = '0;
                    row_held   = 1'b0;
                end else begin
                    upper_row  = row_held ? middle_row : '0;
                    middle_row = cur;
                    row_held   = 1'b1;
                end
            end
            if (i_cfg_wr_en) begin
                grid_width = i_cfg_wr_data;
            end
        end
        o_pending = expected_rows.size();
    end

endmodule

// ===== verif/tb.sv =====
// testbench top for the life row stencil: stimulus, idling and the verdict
module tb;
    localparam int RW          = lgrs_pkg::ROW_WIDTH_DEF;
    // cycles with no accepted word before the run is declared hung
    localparam int QUIET_LIMIT = 3000;
    // settle time after the last expected word, and before a width write
    localparam int SETTLE      = 6;
    localparam int SEG_WORDS   = 200;
    localparam int SEG_COUNT   = 8;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_wr_en;
    logic [lgrs_pkg::GRID_WIDTH_W-1:0] i_cfg_wr_data;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [RW-1:0]                     i_row_cells;
    logic                              i_last_row;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [RW-1:0]                     o_next_row_cells;
    logic                              o_last_out;

    int fail_count;
    int pending;
    // idle chance in percent for each side
    int send_idle_pct;
    int recv_idle_pct;

    life_generation_row_stencil u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_row_cells      (i_row_cells),
        .i_last_row       (i_last_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_next_row_cells (o_next_row_cells),
        .o_last_out       (o_last_out)
    );

    life_row_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_row_cells      (i_row_cells),
        .i_last_row       (i_last_row),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_next_row_cells (o_next_row_cells),
        .i_last_out       (o_last_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 10 unit clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall decided fresh at every falling edge
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // hang detector: any accepted word or a register write counts as progress
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // wide random value with the two halves drawn separately
    function automatic logic [RW-1:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // mix of empty, full, sparse, dense and plain random rows
    function automatic logic [RW-1:0] random_row();
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return rand_wide() & rand_wide();
            end
            4: begin
                return rand_wide() | rand_wide();
            end
            default: begin
                return rand_wide();
            end
        endcase
    endfunction

    // present one word, called at a falling edge, returns at a falling edge;
    // valid is left high so the next word follows without a bubble
    task automatic send_word(input logic [RW-1:0] cells, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_row_cells = cells;
        i_last_row  = last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        @(negedge i_clk);
    endtask

    // sender pauses until every expected word is back, then lets the pipe settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // width change only while the block is quiet
    task automatic write_width(input logic [lgrs_pkg::GRID_WIDTH_W-1:0] w);
        drain();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = w;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // a whole grid of random rows; mostly short, now and then tall
    task automatic send_grid(output int rows);
        if ($urandom_range(9) == 0) begin
            rows = $urandom_range(40, 20);
        end else begin
            rows = $urandom_range(8, 1);
        end
        for (int r = 0; r < rows; r++) begin
            send_word(random_row(), r == rows - 1);
        end
    endtask

    initial begin : stimulus
        logic [lgrs_pkg::GRID_WIDTH_W-1:0] seg_width [SEG_COUNT];
        int                                sent;
        int                                rows;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_row_cells   = '0;
        i_last_row    = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 59;

        seg_width = '{7'd64, 7'd1, 7'd63, 7'd2, 7'd127, 7'd33, 7'd8, 7'd64};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed words at the reset width
        // single row grids: rows above and below are dead
        send_word('1, 1'b1);
        send_word('0, 1'b1);
        // edge columns: cells beyond bit 0 and bit 63 are dead
        send_word(64'h8000_0000_0000_0001, 1'b0);
        send_word(64'hC000_0000_0000_0003, 1'b0);
        send_word(64'h8000_0000_0000_0001, 1'b0);
        send_word('0, 1'b1);
        // full block, overpopulation inside
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        // blinker
        send_word('0, 1'b0);
        send_word(64'h0000_0000_0000_001C, 1'b0);
        send_word('0, 1'b1);
        // glider
        send_word(64'h0000_0000_0000_0002, 1'b0);
        send_word(64'h0000_0000_0000_0004, 1'b0);
        send_word(64'h0000_0000_0000_0007, 1'b0);
        send_word('0, 1'b0);
        send_word('0, 1'b1);
        // checkerboard rows
        send_word(64'h5555_5555_5555_5555, 1'b0);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(64'h5555_5555_5555_5555, 1'b1);

        // width of one: bits above column 0 ignored
        write_width(7'd1);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        // zero width: everything dead
        write_width(7'd0);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        // width past the row clamps to the full row
        write_width(7'd127);
        send_word('1, 1'b0);
        send_word(64'h0000_0000_0000_0000, 1'b1);
        // width changed mid grid: stored rows are masked to the new width
        write_width(7'd64);
        send_word('1, 1'b0);
        send_word(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
        write_width(7'd8);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // random grids, one width per segment, idling pattern rotates
        for (int s = 0; s < SEG_COUNT; s++) begin
            write_width(seg_width[s]);
            if (s < 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 59;
            end else if (s < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < SEG_WORDS) begin
                send_grid(rows);
                sent += rows;
            end
        end

        // wait out the last words and the pipe latency
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lgrs_pkg.sv
rtl/core/lgrs_front.sv
rtl/core/lgrs_fifo.sv
rtl/core/lgrs_back.sv
rtl/core/life_generation_row_stencil.sv
verif/life_row_checker.sv
verif/tb.sv
